>>> design/range_max_segment_tree_macros.svh
// Assertion macros for the range maximum segment tree checker.
// Used by rmst_checker.sv; depends on nothing else.
`ifndef RANGE_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RMST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RMST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define RMST_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rmst_pkg.sv
// Shared constants and types of the range maximum segment tree.
// Used by rmst_ctrl and range_max_segment_tree; depends on nothing.
package rmst_pkg;

    localparam int LEAVES      = 1024;
    localparam int NODE_COUNT  = 2 * LEAVES;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int IDX_BITS    = NODE_BITS + 1;
    localparam int POS_BITS    = 10;
    localparam int BOUND_BITS  = 11;
    localparam int VALUE_BITS  = 17;

    localparam logic signed [VALUE_BITS-1:0] EMPTY_VALUE = '1;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic                  we;
        logic [NODE_BITS-1:0]  waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [NODE_BITS-1:0]  raddr;
    } t_ram_req;

    typedef struct packed {
        logic                         valid;
        logic signed [VALUE_BITS-1:0] data;
    } t_result;

endpackage

>>> design/rmst_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; holds the tree nodes of the segment tree.
module rmst_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rmst_ctrl.sv
// Sequencer of the segment tree: clearing pass, leaf update walk and range query walk.
// Depends on rmst_pkg; drives the node memory and shares one signed max unit.
module rmst_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic [rmst_pkg::POS_BITS-1:0]          i_position,
    input  logic signed [rmst_pkg::VALUE_BITS-1:0] i_new_value,
    input  logic [rmst_pkg::BOUND_BITS-1:0]        i_range_start,
    input  logic [rmst_pkg::BOUND_BITS-1:0]        i_range_end,
    output rmst_pkg::t_ram_req                     o_ram,
    input  logic [rmst_pkg::VALUE_BITS-1:0]        i_rdata,
    output rmst_pkg::t_result                      o_res,
    input  logic                                   i_res_ready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SKIP,
        S_UPD_LEAF,
        S_UPD_COMB,
        S_UPD_READ,
        S_Q_TEST,
        S_Q_LDATA,
        S_Q_RDATA,
        S_Q_DONE
    } t_state;

    localparam int NB = rmst_pkg::NODE_BITS;
    localparam int IB = rmst_pkg::IDX_BITS;
    localparam int VB = rmst_pkg::VALUE_BITS;
    localparam int BB = rmst_pkg::BOUND_BITS;

    t_state                r_state, n_state;
    logic [IB-1:0]         r_lo, n_lo;
    logic [IB-1:0]         r_hi, n_hi;
    logic signed [VB-1:0]  r_acc, n_acc;
    logic signed [VB-1:0]  r_right, n_right;
    logic [NB-1:0]         r_clr, n_clr;

    logic signed [VB-1:0]  cmp_a, cmp_b, cmp_max;
    logic [IB-1:0]         parent, lo_inc, hi_dec;
    logic [BB-1:0]         start_c, end_c;

    assign cmp_max = (cmp_a > cmp_b) ? cmp_a : cmp_b;
    assign parent  = r_lo >> 1;
    assign lo_inc  = r_lo + IB'(1);
    assign hi_dec  = r_hi - IB'(1);
    assign start_c = (i_range_start > BB'(rmst_pkg::LEAVES)) ? BB'(rmst_pkg::LEAVES)
                                                             : i_range_start;
    assign end_c   = (i_range_end > BB'(rmst_pkg::LEAVES)) ? BB'(rmst_pkg::LEAVES)
                                                           : i_range_end;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_acc       = r_acc;
        n_right     = r_right;
        n_clr       = r_clr;
        o_ram       = '0;
        o_res.valid = 1'b0;
        o_res.data  = cmp_max;
        cmp_a       = r_acc;
        cmp_b       = $signed(i_rdata);
        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
                o_ram.wdata = rmst_pkg::EMPTY_VALUE;
                n_clr       = r_clr + NB'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == rmst_pkg::CMD_UPDATE) begin
                        if (IB'(i_position) < IB'(rmst_pkg::LEAVES)) begin
                            n_lo    = IB'(i_position) + IB'(rmst_pkg::LEAVES);
                            n_acc   = i_new_value;
                            n_state = S_UPD_LEAF;
                        end else begin
                            n_state = S_SKIP;
                        end
                    end else begin
                        n_lo    = IB'(start_c) + IB'(rmst_pkg::LEAVES);
                        n_hi    = IB'(end_c) + IB'(rmst_pkg::LEAVES);
                        n_acc   = rmst_pkg::EMPTY_VALUE;
                        n_right = rmst_pkg::EMPTY_VALUE;
                        n_state = S_Q_TEST;
                    end
                end
            end
            S_SKIP: begin
                n_state = S_IDLE;
            end
            S_UPD_LEAF: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_lo[NB-1:0];
                o_ram.wdata = r_acc;
                o_ram.raddr = r_lo[NB-1:0] ^ NB'(1);
                n_state     = S_UPD_COMB;
            end
            S_UPD_COMB: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = parent[NB-1:0];
                o_ram.wdata = cmp_max;
                n_acc       = cmp_max;
                n_lo        = parent;
                if (parent == IB'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UPD_READ;
                end
            end
            S_UPD_READ: begin
                o_ram.raddr = r_lo[NB-1:0] ^ NB'(1);
                n_state     = S_UPD_COMB;
            end
            S_Q_TEST: begin
                if (r_lo >= r_hi) begin
                    n_state = S_Q_DONE;
                end else if (r_lo[0]) begin
                    o_ram.raddr = r_lo[NB-1:0];
                    n_state     = S_Q_LDATA;
                end else if (r_hi[0]) begin
                    o_ram.raddr = hi_dec[NB-1:0];
                    n_state     = S_Q_RDATA;
                end else begin
                    n_lo = r_lo >> 1;
                    n_hi = r_hi >> 1;
                end
            end
            S_Q_LDATA: begin
                n_acc = cmp_max;
                if (r_hi[0]) begin
                    n_lo        = lo_inc;
                    o_ram.raddr = hi_dec[NB-1:0];
                    n_state     = S_Q_RDATA;
                end else begin
                    n_lo    = lo_inc >> 1;
                    n_hi    = r_hi >> 1;
                    n_state = S_Q_TEST;
                end
            end
            S_Q_RDATA: begin
                cmp_a   = r_right;
                n_right = cmp_max;
                n_hi    = hi_dec >> 1;
                n_lo    = r_lo >> 1;
                n_state = S_Q_TEST;
            end
            S_Q_DONE: begin
                cmp_b       = r_right;
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_acc   <= n_acc;
        r_right <= n_right;
    end

endmodule

>>> design/range_max_segment_tree.sv
// Top level of the range maximum segment tree: sequencer, node memory and output register.
// Depends on rmst_pkg, rmst_ram and rmst_ctrl.
//
// The input channel (i_in_valid / o_in_ready) carries one command word. An update
// word writes new_value into leaf position and rebuilds every ancestor; it gives no
// output word. A query word returns on the output channel (o_out_valid / i_out_ready)
// the maximum over leaves [range_start, range_end), bounds clamped to the leaf count,
// or -1 when the range is empty.
// All nodes live in one memory with one write and one registered read port, and one
// max unit is shared by every step. An update is accepted, writes the leaf and reads
// its sibling, then at each level writes the parent with the maximum of the pair and
// reads the parent's sibling, until it writes the root. A query is accepted, then at
// each level reads a node for each range end that needs one, until a test finds the
// range closed, and then hands the word over.
// One word is in work at a time; o_in_ready is high only while the block is idle.
// After reset a clearing pass writes -1 to every node, one per cycle, and o_in_ready
// stays low meanwhile.
// The output word sits in a register; while the receiver stalls, the block can
// still accept and process updates, and a further query waits in its last step
// until the register frees up.
module range_max_segment_tree (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_command,
    input  logic [rmst_pkg::POS_BITS-1:0]          i_position,
    input  logic signed [rmst_pkg::VALUE_BITS-1:0] i_new_value,
    input  logic [rmst_pkg::BOUND_BITS-1:0]        i_range_start,
    input  logic [rmst_pkg::BOUND_BITS-1:0]        i_range_end,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [rmst_pkg::VALUE_BITS-1:0] o_max_value
);

    rmst_pkg::t_ram_req                     ram_req;
    rmst_pkg::t_result                      res;
    logic [rmst_pkg::VALUE_BITS-1:0]        rdata;
    logic                                   res_ready;
    logic                                   r_out_valid;
    logic signed [rmst_pkg::VALUE_BITS-1:0] r_max_value;

    assign res_ready = !r_out_valid || i_out_ready;

    rmst_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_ram         (ram_req),
        .i_rdata       (rdata),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    rmst_ram #(
        .DEPTH (rmst_pkg::NODE_COUNT),
        .WIDTH (rmst_pkg::VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
        if (res_ready && res.valid) begin
            r_max_value <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_value = r_max_value;

endmodule

>>> design/rmst_checker.sv
// Port-level checker of the range maximum segment tree and its bind to the top level.
// Depends on range_max_segment_tree_macros.svh and the top level's ports.
`include "range_max_segment_tree_macros.svh"

module rmst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [16:0] o_max_value
);

    `RMST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_max_value), "output word dropped or changed while stalled")

    `RMST_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n, !o_in_ready && !o_out_valid, "block not quiet after reset")

    `RMST_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "block ready right after accepting a word")

    `RMST_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready), "output word appeared while the block was idle")

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);
